@@ src/mfl_pkg.sv @@
// ----------------------------------------------------------------------------
// mfl_pkg: shared types and constants for the message flood limiter
// Holds the ring geometry, the time width, the verdict codes and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package mfl_pkg;

  // Ring geometry and time width.
  localparam int RING_DEPTH = 16;
  localparam int TIME_BITS  = 32;
  localparam int HEAD_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MCNT_W     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = HEAD_W + 2;

  // Field widths.
  localparam int NOW_W      = 32;
  localparam int MAXM_W     = 5;
  localparam int TICK_W     = 16;
  localparam int VERDICT_W  = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [HEAD_W-1:0]    head_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_LOCKED   = 2'd1,
    VERDICT_NEW_LOCK = 2'd2
  } verdict_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_MSGS     = 2'd0,
    CFG_WINDOW_TICKS = 2'd1,
    CFG_WAIT_DELAY   = 2'd2
  } cfg_idx_t;

  localparam time_t TIME_MAX = '1;

endpackage

@@ src/message_flood_limiter_top.sv @@
// ----------------------------------------------------------------------------
// message_flood_limiter_top: sliding window rate limiter for message attempts
// Keeps a ring of recently accepted timestamps and a lockout end time, and
// gives one verdict word for every timestamp word that comes in.
// ----------------------------------------------------------------------------
// Each word goes through the input register, then the result register.
// Throughput: one word per cycle while the result side is not stalled; the
// ring is held in flip-flops, so the lookup, the window compare and the ring
// write all complete in the single pass.
// Reset (rst_n low, synchronous): ring cleared to zero (empty), head and lockout
// end cleared, registers set to max_msgs 4, window_ticks 40, wait_delay 100.
module message_flood_limiter_top
  import mfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. in_tdata: now[31:0].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. out_tdata: verdict[1:0], remaining[17:2], zeros[23:18].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [MAXM_W-1:0] max_msgs_r;
  logic [TICK_W-1:0] window_ticks_r;
  logic [TICK_W-1:0] wait_delay_r;

  // Limiter state.
  time_t             ring_r [RING_DEPTH];
  head_t             ring_head_r;
  head_t             ring_head_nxt;
  time_t             lock_until_r;
  time_t             lock_until_nxt;

  // Pipeline registers.
  logic              in_valid_r;
  logic [NOW_W-1:0]  in_now_r;
  logic              out_valid_r;
  verdict_t          verdict_r;
  verdict_t          verdict_nxt;
  logic [TICK_W-1:0] remaining_r;
  logic [TICK_W-1:0] remaining_nxt;

  logic              advance;
  logic              ring_wr;

  // Working signals of the single pass.
  logic [NOW_W+TIME_BITS-1:0]  now_ext;
  time_t                       now_t;
  logic [MCNT_W-1:0]           m_eff;
  logic [SUM_W-1:0]            slot_sum;
  logic [SUM_W-1:0]            slot_wrap;
  head_t                       slot;
  head_t                       head_inc;
  time_t                       stamp;
  time_t                       age;
  logic                        in_window;
  logic                        locked;
  logic [TIME_BITS:0]          lock_sum;
  time_t                       lock_new;
  time_t                       diff;
  logic [TIME_BITS+TICK_W-1:0] diff_ext;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    now_ext = {{TIME_BITS{1'b0}}, in_now_r};
    now_t   = now_ext[TIME_BITS-1:0];

    if (32'(max_msgs_r) > 32'(RING_DEPTH)) begin
      m_eff = MCNT_W'(RING_DEPTH);
    end else begin
      m_eff = MCNT_W'(max_msgs_r);
    end

    // Slot max_msgs-1 places behind the head, wrapped round the ring; for a
    // nonzero max_msgs the sum stays below twice the depth, so one subtraction wraps it.
    slot_sum = SUM_W'(ring_head_r) + SUM_W'(RING_DEPTH) + SUM_W'(1) - SUM_W'(m_eff);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot_wrap = slot_sum - SUM_W'(RING_DEPTH);
    end else begin
      slot_wrap = slot_sum;
    end
    slot = slot_wrap[HEAD_W-1:0];

    if (SUM_W'(ring_head_r) + SUM_W'(1) >= SUM_W'(RING_DEPTH)) begin
      head_inc = '0;
    end else begin
      head_inc = ring_head_r + head_t'(1);
    end

    stamp = ring_r[slot];
    age   = now_t - stamp;
    // A stamp later than now counts as inside the window.
    in_window = (stamp > now_t) || (age < time_t'(window_ticks_r));
    locked    = now_t < lock_until_r;

    // The lockout end saturates at the largest time value.
    lock_sum = {1'b0, now_t} + (TIME_BITS+1)'(wait_delay_r);
    if (lock_sum[TIME_BITS]) begin
      lock_new = TIME_MAX;
    end else begin
      lock_new = lock_sum[TIME_BITS-1:0];
    end

    ring_head_nxt  = ring_head_r;
    lock_until_nxt = lock_until_r;
    ring_wr        = 1'b0;
    verdict_nxt    = VERDICT_ACCEPT;
    diff           = '0;

    if (max_msgs_r != '0) begin
      if (locked) begin
        verdict_nxt = VERDICT_LOCKED;
        diff        = lock_until_r - now_t;
      end else if (stamp != '0 && in_window) begin
        verdict_nxt    = VERDICT_NEW_LOCK;
        lock_until_nxt = lock_new;
        diff           = lock_new - now_t;
      end else begin
        ring_head_nxt = head_inc;
        ring_wr       = 1'b1;
      end
    end

    diff_ext = {{TICK_W{1'b0}}, diff};
    if (diff_ext[TIME_BITS+TICK_W-1:TICK_W] != '0) begin
      remaining_nxt = '1;
    end else begin
      remaining_nxt = diff[TICK_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msgs_r     <= MAXM_W'(4);
      window_ticks_r <= TICK_W'(40);
      wait_delay_r   <= TICK_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_MSGS:     max_msgs_r     <= cfg_wdata[MAXM_W-1:0];
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_wdata;
        CFG_WAIT_DELAY:   wait_delay_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limiter state; the ring resets to zero, which marks an empty slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      ring_head_r  <= '0;
      lock_until_r <= '0;
    end else if (advance) begin
      ring_head_r  <= ring_head_nxt;
      lock_until_r <= lock_until_nxt;
      if (ring_wr) begin
        ring_r[ring_head_nxt] <= now_t;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_now_r <= in_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r   <= verdict_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-VERDICT_W-TICK_W){1'b0}}, remaining_r, verdict_r};

  // An accepted word never reports time left on a lockout.
  a_accept_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_ACCEPT |-> remaining_r == '0)
    else $error("accepted word carries nonzero remaining");

  // The ring head moves only when a word is accepted.
  a_head_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && ring_wr) |=> $stable(ring_head_r))
    else $error("ring head moved without an accepted word");

  // A held input word is not lost while the result side stalls.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_now_r))
    else $error("input word dropped while stalled");

  // Every processed word yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed word produced no result");

  // A new lockout never ends before the time that raised it.
  a_new_lock_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    advance && verdict_nxt == VERDICT_NEW_LOCK |=> lock_until_r >= $past(now_t))
    else $error("new lockout ends in the past");

endmodule

@@ tb/sv/message_flood_limiter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_flood_limiter_top_tb: self-checking bench for the flood limiter
// A short table of directed words and register writes, random bursts in phases
// and a closing table are sent with random gaps and back-pressure. Every word
// runs through a local model; results are checked against it or a row's want.
// ----------------------------------------------------------------------------
module message_flood_limiter_top_tb;
  import mfl_pkg::*;

  localparam int   PHASES       = 12;
  localparam int   PHASE_ITEMS  = 125;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   PRINT_LIMIT  = 100;
  localparam time_t PHASE_SPAN  = 32'h1400_0000;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    verdict_t            verdict;
    logic [TICK_W-1:0]   remaining;
  } limit_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] reg_idx;
    time_t                 value;
    logic                  has_want;
    verdict_t              want_verdict;
    logic [TICK_W-1:0]     want_remaining;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the limiter state and its registers.
  time_t             stamp_log [RING_DEPTH];
  head_t             log_head;
  time_t             lock_end;
  logic [MAXM_W-1:0] lim_max;
  logic [TICK_W-1:0] lim_window;
  logic [TICK_W-1:0] lim_wait;

  limit_result_t pending_verdicts [$];
  limit_result_t seen_expect;
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;

  message_flood_limiter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               pending_verdicts.size());
      $display("** message_flood_limiter_top: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [TICK_W-1:0] clip16(input time_t span);
    return (span > time_t'(16'hFFFF)) ? 16'hFFFF : span[TICK_W-1:0];
  endfunction

  // Verdict for one message, updating the local state as the limiter would.
  function automatic limit_result_t judge_message(input time_t now);
    limit_result_t r;
    int unsigned   m;
    head_t         slot;
    time_t         stamp;
    logic          inside_win;
    r.verdict   = VERDICT_ACCEPT;
    r.remaining = '0;
    m = 32'(lim_max);
    if (m == 0)
      return r;
    if (m > RING_DEPTH)
      m = RING_DEPTH;
    if (now < lock_end) begin
      r.verdict   = VERDICT_LOCKED;
      r.remaining = clip16(lock_end - now);
      return r;
    end
    slot  = head_t'((int'(log_head) + RING_DEPTH + 1 - int'(m)) % RING_DEPTH);
    stamp = stamp_log[slot];
    // A stamp later than now counts as inside the window.
    inside_win = (stamp > now) || ((now - stamp) < time_t'(lim_window));
    if (stamp != '0 && inside_win) begin
      if (time_t'(lim_wait) > (TIME_MAX - now))
        lock_end = TIME_MAX;
      else
        lock_end = now + time_t'(lim_wait);
      r.verdict   = VERDICT_NEW_LOCK;
      r.remaining = clip16(lock_end - now);
      return r;
    end
    log_head = log_head + 1'b1;
    stamp_log[log_head] = now;
    return r;
  endfunction

  function automatic stim_row_t item_row(input time_t now);
    return '{1'b0, '0, now, 1'b0, VERDICT_ACCEPT, '0};
  endfunction

  function automatic stim_row_t item_row_want(input time_t now, input verdict_t v,
                                              input logic [TICK_W-1:0] rem);
    return '{1'b0, '0, now, 1'b1, v, rem};
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_ADDR_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    return '{1'b1, idx, time_t'(val), 1'b0, VERDICT_ACCEPT, '0};
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance.
  task automatic send_word(input time_t now, input logic has_want,
                           input verdict_t want_v, input logic [TICK_W-1:0] want_rem);
    limit_result_t predicted;
    limit_result_t wanted;
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predicted = judge_message(now);
    wanted.verdict   = want_v;
    wanted.remaining = want_rem;
    pending_verdicts.push_back(has_want ? wanted : predicted);
    @(negedge clk);
  endtask

  // Lets the limiter run dry before a register write.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_MSGS:     lim_max    = val[MAXM_W-1:0];
      CFG_WINDOW_TICKS: lim_window = val;
      CFG_WAIT_DELAY:   lim_wait   = val;
      default: ;
    endcase
  endtask

  task automatic run_rows(input stim_row_t rows[$]);
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_quiet();
        write_reg(rows[i].reg_idx, rows[i].value[CFG_DATA_W-1:0]);
      end else begin
        send_word(rows[i].value, rows[i].has_want, rows[i].want_verdict,
                  rows[i].want_remaining);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", out_tdata));
      end else begin
        seen_expect = pending_verdicts.pop_front();
        if (out_tdata[VERDICT_W-1:0] != seen_expect.verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d",
                                    out_tdata[VERDICT_W-1:0], seen_expect.verdict));
        if (out_tdata[VERDICT_W +: TICK_W] != seen_expect.remaining)
          report_mismatch($sformatf("remaining %0d, expected %0d",
                                    out_tdata[VERDICT_W +: TICK_W], seen_expect.remaining));
        if (out_tdata[OUT_DATA_W-1:VERDICT_W+TICK_W] != '0)
          report_mismatch($sformatf("padding bits set in %h", out_tdata));
      end
    end
  end

  initial begin
    stim_row_t   opening [$];
    stim_row_t   closing [$];
    time_t       cur;
    int unsigned stride;

    foreach (stamp_log[i])
      stamp_log[i] = '0;
    log_head   = '0;
    lock_end   = '0;
    lim_max    = 5'd4;
    lim_window = 16'd40;
    lim_wait   = 16'd100;

    // The first word logs time zero, which later reads back as an empty slot.
    opening = {
      item_row_want(0,  VERDICT_ACCEPT, 0),
      item_row_want(10, VERDICT_ACCEPT, 0),
      item_row_want(11, VERDICT_ACCEPT, 0),
      item_row_want(12, VERDICT_ACCEPT, 0),
      item_row_want(13, VERDICT_ACCEPT, 0),
      item_row_want(14, VERDICT_NEW_LOCK, 100),
      item_row_want(50, VERDICT_LOCKED, 64),
      item_row(114),
      cfg_row(CFG_MAX_MSGS, 0),
      item_row_want(5, VERDICT_ACCEPT, 0),
      cfg_row(CFG_MAX_MSGS, 16'hFFFF),
      cfg_row(CFG_WINDOW_TICKS, 16'hFFFF),
      cfg_row(CFG_WAIT_DELAY, 0),
      item_row(200),
      item_row(201),
      item_row(202),
      cfg_row(CFG_SPARE_IDX, 16'hFFFF),
      cfg_row(CFG_MAX_MSGS, 1),
      cfg_row(CFG_WINDOW_TICKS, 0),
      cfg_row(CFG_WAIT_DELAY, 16'hFFFF),
      item_row(150),
      item_row(100)
    };

    // Lockout end saturating at the top of the time range; it never clears,
    // so this runs last.
    closing = {
      cfg_row(CFG_MAX_MSGS, 1),
      cfg_row(CFG_WINDOW_TICKS, 16'hFFFF),
      cfg_row(CFG_WAIT_DELAY, 16'hFFFF),
      item_row(32'hFFFF_FF00),
      item_row(32'hFFFF_FF00),
      item_row(32'hFFFF_FFFF),
      item_row(32'hFFFF_FFFF),
      cfg_row(CFG_MAX_MSGS, 0),
      item_row_want(32'hFFFF_FFFF, VERDICT_ACCEPT, 0)
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_rows(opening);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      calm = (p == 4 || p == 5);
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_MAX_MSGS, 0);
        1:       write_reg(CFG_MAX_MSGS, 1);
        2:       write_reg(CFG_MAX_MSGS, CFG_DATA_W'(RING_DEPTH));
        3:       write_reg(CFG_MAX_MSGS, CFG_DATA_W'($urandom_range(RING_DEPTH + 1, 31)));
        default: write_reg(CFG_MAX_MSGS, CFG_DATA_W'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_WINDOW_TICKS, 0);
        1:       write_reg(CFG_WINDOW_TICKS, 16'hFFFF);
        2:       write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        default: write_reg(CFG_WINDOW_TICKS, CFG_DATA_W'($urandom_range(5, 300)));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_WAIT_DELAY, 0);
        1:       write_reg(CFG_WAIT_DELAY, 16'hFFFF);
        2:       write_reg(CFG_WAIT_DELAY, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        default: write_reg(CFG_WAIT_DELAY, CFG_DATA_W'($urandom_range(1, 400)));
      endcase
      case ($urandom_range(0, 4))
        0:       stride = 0;
        1:       stride = 1;
        2:       stride = 4;
        3:       stride = 20;
        default: stride = 150;
      endcase
      // Each phase starts well past anything the previous one could lock.
      cur = time_t'(p) * PHASE_SPAN + time_t'($urandom_range(0, 32'h0FFF_FFFF));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        cur = cur + time_t'($urandom_range(0, stride));
        if (cur >= 64 && $urandom_range(0, 99) < 5)
          send_word(cur - time_t'($urandom_range(1, 30)), 1'b0, VERDICT_ACCEPT, '0);
        else
          send_word(cur, 1'b0, VERDICT_ACCEPT, '0);
      end
    end

    calm = 1'b0;
    run_rows(closing);
    wait_quiet();
    repeat (8) @(negedge clk);

    if (mismatches == 0)
      $display("** message_flood_limiter_top: PASSED **");
    else
      $display("** message_flood_limiter_top: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
src/mfl_pkg.sv
src/message_flood_limiter_top.sv
tb/sv/message_flood_limiter_top_tb.sv
